// ----- rtl/vector_norm_limiter_core_assert.svh -----
// assertion macros for the vector norm limiter
`ifndef VECTOR_NORM_LIMITER_CORE_ASSERT_SVH
`define VECTOR_NORM_LIMITER_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define VNL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define VNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/vnl_pkg.sv -----
//------------------------------------------------------------------------------
// vnl_pkg
// shared widths and the cell request type of the norm limiter
//------------------------------------------------------------------------------
package vnl_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int MAG_W      = DATA_WIDTH;         // magnitude fits 2^(W-1)
    localparam int SQ_W       = 2 * DATA_WIDTH;     // sum of squares
    localparam int LIM_W      = DATA_WIDTH - 1;
    localparam int ROOT_W     = DATA_WIDTH;         // root <= 2^(W-1)*sqrt2
    localparam int PROD_W     = MAG_W + LIM_W;
    localparam int TDATA_W    = ((3 * DATA_WIDTH - 1 + 7) / 8) * 8;
    localparam int ODATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int SQ_IDX_W   = $clog2(ROOT_W);     // root bit index
    localparam int DV_IDX_W   = $clog2(PROD_W);     // quotient bit index

    // request moving through the cell chain
    typedef struct packed {
        logic                  vld;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [LIM_W-1:0]      lim;
        logic [MAG_W-1:0]      ax;
        logic [MAG_W-1:0]      ay;
        logic [SQ_W-1:0]       rem;   // square root remainder
        logic [ROOT_W-1:0]     root;
        logic [PROD_W-1:0]     px;    // dividend / remainder for x
        logic [PROD_W-1:0]     py;
        logic [PROD_W-1:0]     qx;
        logic [PROD_W-1:0]     qy;
    } t_req;

endpackage

// ----- rtl/vnl_sqrt_cell.sv -----
//------------------------------------------------------------------------------
// vnl_sqrt_cell
// one root bit per cell, restoring square root on the remainder
//------------------------------------------------------------------------------
module vnl_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [vnl_pkg::SQ_IDX_W-1:0]  i_bit,   // root bit this cell decides
    input  vnl_pkg::t_req                 i_req,
    output vnl_pkg::t_req                 o_req
);
    vnl_pkg::t_req r_req, n_req;
    logic [vnl_pkg::SQ_W:0] w_trial;
    logic [vnl_pkg::SQ_W:0] w_shift;

    always_comb begin
        n_req   = i_req;
        w_shift = {1'b0, vnl_pkg::SQ_W'(i_req.root)} << (i_bit + 1);
        w_trial = w_shift + ({{vnl_pkg::SQ_W{1'b0}}, 1'b1} << (2 * i_bit));
        if ({1'b0, i_req.rem} >= w_trial) begin
            n_req.rem  = vnl_pkg::SQ_W'({1'b0, i_req.rem} - w_trial);
            n_req.root = i_req.root | (vnl_pkg::ROOT_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld <= 1'b0;
        end else if (i_en) begin
            r_req.vld <= n_req.vld;
        end
        if (i_en) begin
            r_req.x    <= n_req.x;    r_req.y    <= n_req.y;
            r_req.lim  <= n_req.lim;  r_req.ax   <= n_req.ax;
            r_req.ay   <= n_req.ay;   r_req.rem  <= n_req.rem;
            r_req.root <= n_req.root; r_req.px   <= n_req.px;
            r_req.py   <= n_req.py;   r_req.qx   <= n_req.qx;
            r_req.qy   <= n_req.qy;
        end
    end

    assign o_req = r_req;
endmodule

// ----- rtl/vnl_div_cell.sv -----
//------------------------------------------------------------------------------
// vnl_div_cell
// one quotient bit per cell for both components, restoring division by root
//------------------------------------------------------------------------------
module vnl_div_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [vnl_pkg::DV_IDX_W-1:0]  i_bit,   // quotient bit this cell decides
    input  vnl_pkg::t_req                 i_req,
    output vnl_pkg::t_req                 o_req
);
    vnl_pkg::t_req r_req, n_req;
    logic [vnl_pkg::PROD_W+vnl_pkg::ROOT_W-1:0] w_d;

    always_comb begin
        n_req = i_req;
        w_d   = {vnl_pkg::PROD_W'(0), i_req.root} << i_bit;
        if ({vnl_pkg::ROOT_W'(0), i_req.px} >= w_d) begin
            n_req.px = vnl_pkg::PROD_W'({vnl_pkg::ROOT_W'(0), i_req.px} - w_d);
            n_req.qx = i_req.qx | (vnl_pkg::PROD_W'(1) << i_bit);
        end
        if ({vnl_pkg::ROOT_W'(0), i_req.py} >= w_d) begin
            n_req.py = vnl_pkg::PROD_W'({vnl_pkg::ROOT_W'(0), i_req.py} - w_d);
            n_req.qy = i_req.qy | (vnl_pkg::PROD_W'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld <= 1'b0;
        end else if (i_en) begin
            r_req.vld <= n_req.vld;
        end
        if (i_en) begin
            r_req.x    <= n_req.x;    r_req.y    <= n_req.y;
            r_req.lim  <= n_req.lim;  r_req.ax   <= n_req.ax;
            r_req.ay   <= n_req.ay;   r_req.rem  <= n_req.rem;
            r_req.root <= n_req.root; r_req.px   <= n_req.px;
            r_req.py   <= n_req.py;   r_req.qx   <= n_req.qx;
            r_req.qy   <= n_req.qy;
        end
    end

    assign o_req = r_req;
endmodule

// ----- rtl/vector_norm_limiter_core.sv -----
//------------------------------------------------------------------------------
// vector_norm_limiter_core
// limits the length of a 2-D Q1.15 vector to a given norm
//------------------------------------------------------------------------------
// s_axis carries one request per beat: x_in, y_in and norm_limit in tdata.
// m_axis returns x_out and y_out for every request, in order.
// The datapath is a chain of cells: an input stage squares and sums, then one
// cell per root bit (16), a stage forming |c|*limit, one cell per quotient bit
// (31), and an output stage applying signs. One request is taken every cycle
// while the chain advances.
// The whole chain moves only when the output register is empty or is being
// taken, so a stall on m_axis holds every cell and drops s_axis_tready.
// Synchronous active-low reset empties every cell; data is not cleared.
// Vectors whose floored norm does not exceed the limit pass unchanged.
//------------------------------------------------------------------------------
`include "vector_norm_limiter_core_assert.svh"

module vector_norm_limiter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // x_in[15:0], y_in[31:16], norm_limit[46:32], zero fill
    input  logic [vnl_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // x_out[15:0], y_out[31:16]
    output logic [vnl_pkg::ODATA_W-1:0] m_axis_tdata
);
    localparam int W  = vnl_pkg::DATA_WIDTH;
    localparam int NS = vnl_pkg::ROOT_W;
    localparam int ND = vnl_pkg::PROD_W;

    logic w_en;
    vnl_pkg::t_req w_in, r_s0;
    vnl_pkg::t_req w_sq [NS+1];
    vnl_pkg::t_req w_dv [ND+1];
    vnl_pkg::t_req n_mul, r_mul;
    logic [W-1:0] w_ax, w_ay;
    logic r_ovld;
    logic [W-1:0] r_xo, r_yo, n_xo, n_yo;

    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? W'(-v) : v;
    endfunction

    always_comb begin
        w_ax      = f_mag(s_axis_tdata[W-1:0]);
        w_ay      = f_mag(s_axis_tdata[2*W-1:W]);
        w_in      = '0;
        w_in.vld  = s_axis_tvalid;
        w_in.x    = s_axis_tdata[W-1:0];
        w_in.y    = s_axis_tdata[2*W-1:W];
        w_in.lim  = s_axis_tdata[3*W-2:2*W];
        w_in.ax   = w_ax;
        w_in.ay   = w_ay;
    end

    // input stage: sum of squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (w_en) begin
            r_s0.vld <= w_in.vld;
        end
        if (w_en) begin
            r_s0.x   <= w_in.x;   r_s0.y  <= w_in.y;
            r_s0.lim <= w_in.lim; r_s0.ax <= w_in.ax;
            r_s0.ay  <= w_in.ay;
            r_s0.rem <= vnl_pkg::SQ_W'(w_ax * w_ax) + vnl_pkg::SQ_W'(w_ay * w_ay);
            r_s0.root <= '0; r_s0.px <= '0; r_s0.py <= '0;
            r_s0.qx   <= '0; r_s0.qy <= '0;
        end
    end

    assign w_sq[0] = r_s0;
    for (genvar g = 0; g < NS; g++) begin : g_sq
        vnl_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_bit(vnl_pkg::SQ_IDX_W'(NS - 1 - g)),
            .i_req(w_sq[g]), .o_req(w_sq[g+1])
        );
    end

    // product stage: |c| * limit
    always_comb begin
        n_mul    = w_sq[NS];
        n_mul.px = vnl_pkg::PROD_W'(w_sq[NS].ax * w_sq[NS].lim);
        n_mul.py = vnl_pkg::PROD_W'(w_sq[NS].ay * w_sq[NS].lim);
        n_mul.qx = '0;
        n_mul.qy = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.vld <= 1'b0;
        end else if (w_en) begin
            r_mul.vld <= n_mul.vld;
        end
        if (w_en) begin
            r_mul.x   <= n_mul.x;   r_mul.y    <= n_mul.y;
            r_mul.lim <= n_mul.lim; r_mul.ax   <= n_mul.ax;
            r_mul.ay  <= n_mul.ay;  r_mul.rem  <= n_mul.rem;
            r_mul.root <= n_mul.root; r_mul.px <= n_mul.px;
            r_mul.py  <= n_mul.py;  r_mul.qx   <= n_mul.qx;
            r_mul.qy  <= n_mul.qy;
        end
    end

    assign w_dv[0] = r_mul;
    for (genvar g = 0; g < ND; g++) begin : g_dv
        vnl_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_bit(vnl_pkg::DV_IDX_W'(ND - 1 - g)),
            .i_req(w_dv[g]), .o_req(w_dv[g+1])
        );
    end

    // output stage: pass-through or signed quotient
    always_comb begin
        if (w_dv[ND].root > vnl_pkg::ROOT_W'(w_dv[ND].lim)) begin
            n_xo = w_dv[ND].x[W-1] ? W'(-w_dv[ND].qx) : W'(w_dv[ND].qx);
            n_yo = w_dv[ND].y[W-1] ? W'(-w_dv[ND].qy) : W'(w_dv[ND].qy);
        end else begin
            n_xo = w_dv[ND].x;
            n_yo = w_dv[ND].y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_dv[ND].vld;
        end
        if (w_en) begin
            r_xo <= n_xo;
            r_yo <= n_yo;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = vnl_pkg::ODATA_W'({r_yo, r_xo});

    // a stalled result holds its value
    `VNL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    // ready is high whenever the output register is empty
    `VNL_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    // root never exceeds the magnitude bound
    `VNL_ASSERT_IMP(a_root, i_clk, i_rst_n, w_dv[ND].vld,
        w_dv[ND].root <= vnl_pkg::ROOT_W'(46341))
endmodule

// ----- sim/vector_norm_limiter_core_tb.sv -----
//------------------------------------------------------------------------------
// vector_norm_limiter_core_tb
// self-checking bench for the 2-D vector norm limiter
//------------------------------------------------------------------------------
// Vectors and limits go in on s_axis; a bit-true model of the floored norm
// and the truncating rescale predicts x_out and y_out, which are compared in
// order against every m_axis beat. Directed corners come first, then random
// vectors biased toward lengths near the limit, some with gaps and stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector_norm_limiter_core_tb;

    localparam int LATENCY = 50;
    localparam int DW      = vnl_pkg::DATA_WIDTH;
    localparam int SQW     = vnl_pkg::SQ_W;
    localparam int LW      = vnl_pkg::LIM_W;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [vnl_pkg::TDATA_W-1:0]   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [vnl_pkg::ODATA_W-1:0]   m_axis_tdata;

    typedef struct packed {
        logic [DW-1:0] xo;
        logic [DW-1:0] yo;
    } t_limited;

    t_limited limited_q[$];
    int       err_cnt;
    bit       src_gaps;
    bit       sink_stalls;
    int       hold_off_cycles;

    vector_norm_limiter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [DW-1:0] floor_sqrt(logic [SQW-1:0] n);
        logic [SQW-1:0] root;
        logic [SQW-1:0] rem;
        logic [SQW-1:0] bitv;
        root = '0;
        rem  = n;
        bitv = SQW'(1) << (SQW - 2);
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] rescale(logic [DW-1:0] c,
                                              logic [LW-1:0] lim,
                                              logic [DW-1:0] norm);
        logic [DW:0]   mag;
        logic [47:0]   q;
        mag = c[DW-1] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
        q   = (48'(mag) * 48'(lim)) / 48'(norm);
        if (c[DW-1]) q = -q;
        return q[DW-1:0];
    endfunction

    function automatic t_limited limit_vector(logic [DW-1:0] x,
                                              logic [DW-1:0] y,
                                              logic [LW-1:0] lim);
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic [SQW-1:0]       sum;
        logic [DW-1:0]        norm;
        t_limited             r;
        sx   = x;
        sy   = y;
        sum  = SQW'(longint'(sx) * sx + longint'(sy) * sy);
        norm = floor_sqrt(sum);
        if (norm > {1'b0, lim}) begin
            r.xo = rescale(x, lim, norm);
            r.yo = rescale(y, lim, norm);
        end else begin
            r.xo = x;
            r.yo = y;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got,
                                   logic [DW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // one request; a random gap, when enabled, may come before the offer
    task automatic send_vector(logic [DW-1:0] x, logic [DW-1:0] y,
                               logic [LW-1:0] lim);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vnl_pkg::TDATA_W'({lim, y, x});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        limited_q.push_back(limit_vector(x, y, lim));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (limited_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic logic [LW-1:0] limit_near(logic [DW-1:0] x,
                                                 logic [DW-1:0] y);
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        int                   n;
        sx = x;
        sy = y;
        n  = int'(floor_sqrt(SQW'(longint'(sx) * sx + longint'(sy) * sy)));
        n  = n + int'($urandom_range(0, 4)) - 2;
        if (n < 0) n = 0;
        if (n > 32767) n = 32767;
        return LW'(n);
    endfunction

    // random length, often close to the limit
    task automatic send_random();
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [LW-1:0] lim;
        int            sel;
        x   = DW'($urandom);
        y   = DW'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            lim = LW'($urandom);
        end else if (sel < 6) begin
            x   = $signed(x) >>> $urandom_range(0, 15);
            y   = $signed(y) >>> $urandom_range(0, 15);
            lim = limit_near(x, y);
        end else if (sel < 8) begin
            lim = limit_near(x, y);
        end else if (sel == 8) begin
            lim = $urandom_range(0, 3) == 0 ? '0 : {LW{1'b1}};
        end else begin
            x   = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            lim = LW'($urandom);
        end
        send_vector(x, y, lim);
    endtask

    task automatic test_corners();
        send_vector(16'h0000, 16'h0000, 15'h0000);
        send_vector(16'h0000, 16'h0000, 15'h7fff);
        send_vector(16'h8000, 16'h8000, 15'h7fff);
        send_vector(16'h8000, 16'h8000, 15'h0000);
        send_vector(16'h8000, 16'h8000, 15'h4000);
        send_vector(16'h7fff, 16'h7fff, 15'h7fff);
        send_vector(16'h7fff, 16'h8000, 15'h1234);
        send_vector(16'h8000, 16'h0000, 15'h7fff);
        send_vector(16'h0000, 16'h7fff, 15'h7ffe);
        send_vector(16'h0003, 16'h0004, 15'h0005);
        send_vector(16'h0003, 16'h0004, 15'h0004);
        send_vector(16'hfffd, 16'hfffc, 15'h0004);
        send_vector(16'h0001, 16'h0000, 15'h0000);
        send_vector(16'h0001, 16'h0001, 15'h0001);
        send_vector(16'hffff, 16'h0001, 15'h0000);
        send_vector(16'h0c00, 16'hf400, 15'h0800);
        send_vector(16'h5555, 16'haaaa, 15'h2aaa);
        send_vector(16'haaaa, 16'h5555, 15'h5555);
        go_idle();
        drain();
    endtask

    task automatic test_random(int count);
        repeat (count) send_random();
        go_idle();
    endtask

    // sink holds off long enough for the chain to fill and push back
    task automatic test_backpressure();
        hold_off_cycles = 200;
        repeat (120) send_random();
        go_idle();
        drain();
    endtask

    task automatic test_full_rate(int count);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (count) send_random();
        go_idle();
    endtask

    // sink: random stall bursts and one long hold-off on request
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_limited want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (limited_q.size() == 0) begin
                $display("unexpected result %h at %0t", m_axis_tdata, $time);
                err_cnt++;
            end else begin
                want = limited_q.pop_front();
                if (m_axis_tdata[15:0] !== want.xo)
                    report_mismatch("x_out", m_axis_tdata[15:0], want.xo);
                if (m_axis_tdata[31:16] !== want.yo)
                    report_mismatch("y_out", m_axis_tdata[31:16], want.yo);
            end
        end
    end

    initial begin
        err_cnt         = 0;
        hold_off_cycles = 0;
        src_gaps        = 1'b1;
        sink_stalls     = 1'b1;
        i_rst_n         <= 1'b0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random(900);
        drain();
        test_backpressure();
        test_random(500);
        test_full_rate(300);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (err_cnt == 0 && limited_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vnl_pkg.sv
rtl/vnl_sqrt_cell.sv
rtl/vnl_div_cell.sv
rtl/vector_norm_limiter_core.sv
sim/vector_norm_limiter_core_tb.sv
